// ----- hdl/ufcd_pkg.sv -----
// Package: widths, defaults and sequencer states of the union-find cycle detector.
`default_nettype none
package ufcd_pkg;
  localparam int NODE_W = 8;
  localparam int MAX_NODES_DEF = 256;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_RDA,
    ST_RDB,
    ST_CMP,
    ST_SRD,
    ST_SWR,
    ST_FIN
  } ufcd_state_t;
endpackage
`default_nettype wire

// ----- hdl/ufcd_if.sv -----
// Interfaces: edge request channel and result channel.
`default_nettype none
interface ufcd_in_if;
  import ufcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic              restart;

  modport source (output valid, output node_a, output node_b, output restart, input ready);
  modport sink   (input valid, input node_a, input node_b, input restart, output ready);
endinterface

interface ufcd_out_if;
  logic valid;
  logic ready;
  logic redundant;
  logic first_redundant;

  modport source (output valid, output redundant, output first_redundant, input ready);
  modport sink   (input valid, input redundant, input first_redundant, output ready);
endinterface
`default_nettype wire

// ----- hdl/union_find_cycle_detector.sv -----
// Top level: quick-find label store with a sequenced read/compare/relabel sweep.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    node_a[7:0], node_b[7:0], restart
//   out_ch    out   valid/ready    redundant, first_redundant
//
// Each request, accept to next accept: an endpoint out of range goes straight
// to the result, matching labels end after the compare, and a merge relabels
// by reading every entry and writing back those holding node_a's label, through
// the single memory port pair and one label comparator.
// A restart runs an identity fill of the label store before the edge is handled.
// After reset an identity fill runs with in_ch.ready low.
// The result register frees the sequencer; a stalled result holds only the
// next request's final step.
`default_nettype none
module union_find_cycle_detector #(
  parameter int MAX_NODES = ufcd_pkg::MAX_NODES_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  ufcd_in_if.sink   in_ch,
  ufcd_out_if.source out_ch
);
  import ufcd_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int NW = ((IW > NODE_W) ? IW : NODE_W) + 1;
  localparam logic [IW-1:0] LAST = IW'(MAX_NODES - 1);

  ufcd_state_t state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [NODE_W-1:0] a_r, b_r;
  logic [IW-1:0] la_r, lb_r;
  logic found_r;
  logic res_red_r, res_first_r;
  logic out_valid_r, out_red_r, out_first_r;

  logic [IW-1:0] mem [MAX_NODES];
  logic [IW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr, mem_waddr, mem_wdata;
  logic mem_we;

  logic [NW-1:0] a_ext, b_ext;
  logic rng_ok, lbl_eq, in_acc, out_load;

  assign a_ext  = NW'(a_r);
  assign b_ext  = NW'(b_r);
  assign rng_ok = (a_ext < NW'(MAX_NODES)) && (b_ext < NW'(MAX_NODES));
  assign lbl_eq = (rd_data_r == la_r);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_INIT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) state_nxt = in_ch.restart ? ST_CLR : ST_RDA;
      end
      ST_CLR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_RDA;
          cnt_nxt   = '0;
        end
      end
      ST_RDA: state_nxt = rng_ok ? ST_RDB : ST_FIN;
      ST_RDB: state_nxt = ST_CMP;
      ST_CMP: begin
        cnt_nxt   = '0;
        state_nxt = lbl_eq ? ST_FIN : ST_SRD;
      end
      ST_SRD: state_nxt = ST_SWR;
      ST_SWR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) state_nxt = ST_FIN;
        else state_nxt = ST_SRD;
      end
      ST_FIN: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cnt_r;
    mem_wdata   = cnt_r;
    rd_addr     = cnt_r;
    case (state_r)
      ST_INIT: mem_we = 1'b1;
      ST_IDLE: in_ch.ready = 1'b1;
      ST_CLR:  mem_we = 1'b1;
      ST_RDA:  rd_addr = a_ext[IW-1:0];
      ST_RDB:  rd_addr = b_ext[IW-1:0];
      ST_SWR: begin
        mem_we    = lbl_eq;
        mem_wdata = lb_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc && in_ch.restart) found_r <= 1'b0;
      else if (state_r == ST_CMP && lbl_eq) found_r <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r         <= in_ch.node_a;
      b_r         <= in_ch.node_b;
      res_red_r   <= 1'b0;
      res_first_r <= 1'b0;
    end
    if (state_r == ST_RDB) la_r <= rd_data_r;
    if (state_r == ST_CMP) begin
      lb_r <= rd_data_r;
      if (lbl_eq) begin
        res_red_r   <= 1'b1;
        res_first_r <= !found_r;
      end
    end
    if (out_load) begin
      out_red_r   <= res_red_r;
      out_first_r <= res_first_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.redundant       = out_red_r;
  assign out_ch.first_redundant = out_first_r;

  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_INIT || state_r == ST_CLR || state_r == ST_SWR))
    else $error("label store written outside fill or sweep");

  a_restart_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.restart) |=> (state_r == ST_CLR))
    else $error("restart did not start identity fill");

  a_sweep_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRD) |-> (la_r != lb_r))
    else $error("relabel sweep with equal labels");

  a_first_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_first_r || out_red_r))
    else $error("first_redundant without redundant");

  a_found_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && res_red_r) |-> found_r)
    else $error("redundant edge left found flag clear");
endmodule
`default_nettype wire
